@@ sv/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Types and constants shared by the buddy allocator files.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned NumLevels = 7;
  localparam int unsigned SlotTotal = 127;
  localparam int unsigned Records   = 128;

  localparam logic [6:0] LvlBase [NumLevels] = '{7'd0, 7'd1, 7'd3, 7'd7, 7'd15, 7'd31, 7'd63};
  localparam logic [6:0] LvlCap  [NumLevels] = '{7'd1, 7'd2, 7'd4, 7'd8, 7'd16, 7'd32, 7'd64};

  localparam logic [0:0] CmdAlloc   = 1'b0;
  localparam logic [0:0] CmdRelease = 1'b1;

  typedef struct packed {
    logic [0:0]  command;
    logic [15:0] request_size;
    logic [9:0]  block_address;
  } req_t;

  typedef struct packed {
    logic [9:0] granted_address;
    logic [0:0] success;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_FINDLVL, ST_SPLIT_RD, ST_SPLIT_WAIT, ST_SPLIT_WR,
    ST_POP_RD, ST_POP_WAIT, ST_REL_CLR, ST_SCAN, ST_SCAN_WAIT, ST_SHIFT_WAIT,
    ST_SHIFT, ST_PUSH, ST_DONE
  } state_t;

  function automatic logic [9:0] lvl_size(input logic [2:0] l);
    return 10'(11'd512 >> l);
  endfunction

  // level for request_size+1 (or recorded size+1)
  function automatic logic [2:0] level_for(input logic [16:0] need);
    logic [2:0] l;
    l = 3'd6;
    if (need > 17'd8)   l = 3'd5;
    if (need > 17'd16)  l = 3'd4;
    if (need > 17'd32)  l = 3'd3;
    if (need > 17'd64)  l = 3'd2;
    if (need > 17'd128) l = 3'd1;
    if (need > 17'd256) l = 3'd0;
    return l;
  endfunction

endpackage

@@ sv/buddy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator over a 1024-word heap, blocks of 8 to 512 words.
// ----------------------------------------------------------------------------
// One command at a time. Free lists sit in a 127-entry slot memory with one
// read port and one write port; block records in a 128-entry memory. Allocate
// takes a block from the first non-empty list of the needed size or larger and
// splits it down level by level; release scans each level's list for the
// buddy, compacts the list on a match and merges upward, then pushes the
// block. The reset free lists hold 512, 256 and 128; they are loaded right
// after reset, with in_ready low.
module buddy_block_allocator (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bba_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bba_pkg::rsp_t  out_data
);
  import bba_pkg::*;

  logic [9:0]  slots [SlotTotal];
  logic [15:0] sizes [Records];
  logic [Records-1:0] used;
  logic [6:0]  count [NumLevels];

  state_t state, state_next;
  req_t   req;
  logic [2:0] lev, j;
  logic [9:0] a, b;
  logic [6:0] i;
  logic [9:0] rdata;
  logic [15:0] srec;
  logic [6:0]  ridx;

  logic       wr_en;
  logic [6:0] waddr, raddr;
  logic [9:0] wdata;

  logic [1:0] init_cnt;
  logic       init_done;
  logic       oversize, rel_bad, shift_last;

  always_ff @(posedge clk) begin
    if (wr_en) slots[waddr] <= wdata;
    if (state == ST_POP_WAIT) sizes[rdata[9:3]] <= req.request_size;
    rdata <= slots[raddr];
    srec  <= sizes[ridx];
  end

  logic [6:0] cnt_j, cnt_lev;
  assign cnt_j      = count[j];
  assign cnt_lev    = count[lev];
  assign ridx       = req.block_address[9:3];
  assign init_done  = init_cnt == 2'd3;
  assign oversize   = ({1'b0, req.request_size} + 17'd1) > 17'd512;
  assign rel_bad    = req.block_address[2:0] != 3'd0 || !used[ridx];
  assign shift_last = (i + 7'd1) >= cnt_lev;

  always_comb begin
    state_next = state;
    wr_en = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state)
      ST_IDLE:       if (in_valid && init_done) state_next = ST_DECODE;
      ST_DECODE: begin
        if (req.command == CmdAlloc) state_next = oversize ? ST_DONE : ST_FINDLVL;
        else state_next = rel_bad ? ST_DONE : ST_REL_CLR;
      end
      ST_FINDLVL: begin
        if (cnt_j != 7'd0) state_next = (j == lev) ? ST_POP_RD : ST_SPLIT_RD;
        else if (j == 3'd0) state_next = ST_DONE;
      end
      ST_SPLIT_RD: begin
        raddr = LvlBase[j] + cnt_j - 7'd1;
        state_next = ST_SPLIT_WAIT;
      end
      ST_SPLIT_WAIT: state_next = ST_SPLIT_WR;
      ST_SPLIT_WR: begin
        // upper half then lower half
        wr_en = 1'b1;
        waddr = LvlBase[j+3'd1] + count[j+3'd1] + {6'd0, i[0]};
        wdata = i[0] ? a : a + (lvl_size(j) >> 1);
        if (i[0]) state_next = (j + 3'd1 == lev) ? ST_POP_RD : ST_SPLIT_RD;
      end
      ST_POP_RD: begin
        raddr = LvlBase[lev] + cnt_lev - 7'd1;
        state_next = ST_POP_WAIT;
      end
      ST_POP_WAIT:   state_next = ST_DONE;
      ST_REL_CLR:    state_next = ST_SCAN;
      ST_SCAN: begin
        if (lev == 3'd0 || i >= cnt_lev) state_next = ST_PUSH;
        else begin
          raddr = LvlBase[lev] + i;
          state_next = ST_SCAN_WAIT;
        end
      end
      ST_SCAN_WAIT:  state_next = (rdata == b) ? ST_SHIFT : ST_SCAN;
      ST_SHIFT: begin
        if (shift_last) state_next = ST_SCAN;
        else begin
          raddr = LvlBase[lev] + i + 7'd1;
          state_next = ST_SHIFT_WAIT;
        end
      end
      ST_SHIFT_WAIT: begin
        wr_en = 1'b1;
        waddr = LvlBase[lev] + i;
        wdata = rdata;
        state_next = ST_SHIFT;
      end
      ST_PUSH: begin
        wr_en = cnt_lev < LvlCap[lev];
        waddr = LvlBase[lev] + cnt_lev;
        wdata = a;
        state_next = ST_DONE;
      end
      ST_DONE:       if (out_ready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
    // reset free lists: 512, 256, 128 at levels 0..2
    if (!init_done) begin
      wr_en = 1'b1;
      waddr = LvlBase[init_cnt];
      wdata = lvl_size({1'b0, init_cnt});
    end
  end

  assign in_ready  = state == ST_IDLE && init_done;
  assign out_valid = state == ST_DONE;

  always_ff @(posedge clk) begin
    if (rst) init_cnt <= '0;
    else if (!init_done) init_cnt <= init_cnt + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
      for (int k = 0; k < int'(NumLevels); k++) count[k] <= (k < 3) ? 7'd1 : 7'd0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (in_valid && in_ready) begin
          req <= in_data;
          out_data <= '0;
        end
        ST_DECODE: begin
          if (req.command == CmdAlloc) begin
            lev <= level_for({1'b0, req.request_size} + 17'd1);
            j   <= level_for({1'b0, req.request_size} + 17'd1);
          end
        end
        ST_FINDLVL: if (cnt_j == 7'd0 && j != 3'd0) j <= j - 3'd1;
        ST_SPLIT_WAIT: begin
          a <= rdata;
          count[j] <= cnt_j - 7'd1;
          i <= '0;
        end
        ST_SPLIT_WR: begin
          if (i[0]) begin
            count[j+3'd1] <= count[j+3'd1] + 7'd2;
            j <= j + 3'd1;
          end
          i <= i + 7'd1;
        end
        ST_POP_WAIT: begin
          count[lev] <= cnt_lev - 7'd1;
          used[rdata[9:3]] <= 1'b1;
          out_data.granted_address <= rdata;
          out_data.success <= 1'b1;
        end
        ST_REL_CLR: begin
          // recorded block covers granules beyond its start only through
          // the start record; those are never set, so clearing one suffices
          used[ridx] <= 1'b0;
          lev <= level_for({1'b0, srec} + 17'd1);
          a <= req.block_address;
          b <= req.block_address ^ lvl_size(level_for({1'b0, srec} + 17'd1));
          i <= '0;
          out_data.success <= 1'b1;
        end
        ST_SCAN_WAIT: if (rdata != b) i <= i + 7'd1;
        ST_SHIFT: begin
          if (shift_last) begin
            count[lev] <= cnt_lev - 7'd1;
            lev <= lev - 3'd1;
            a <= a & ~lvl_size(lev);
            b <= (a & ~lvl_size(lev)) ^ lvl_size(lev - 3'd1);
            i <= '0;
          end
        end
        ST_SHIFT_WAIT: i <= i + 7'd1;
        ST_PUSH: if (cnt_lev < LvlCap[lev]) count[lev] <= cnt_lev + 7'd1;
        default: ;
      endcase
    end
  end
endmodule
